FILE: sv/anp_pkg.sv
// Shared types, parse phase codes and character constants for the ASCII number parser.
`default_nettype none

package anp_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ZERO  = 3'd1;
    localparam logic [2:0] PH_DEC   = 3'd2;
    localparam logic [2:0] PH_HEX   = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int unsigned VALUE_W = 32;

    // Per-string parse state.
    typedef struct packed {
        logic [2:0]         phase;
        logic [VALUE_W-1:0] acc;
        logic               neg;
    } anp_state_t;

endpackage

`default_nettype wire

FILE: sv/anp_step.sv
// Next-state logic of the parser: consumes one character and updates the string state.
`default_nettype none

module anp_step (
    input  anp_pkg::anp_state_t        state,
    input  logic [7:0]                 char_code,
    input  logic                       signed_mode,
    output anp_pkg::anp_state_t        state_next,
    output logic [anp_pkg::VALUE_W-1:0] result
);
    import anp_pkg::*;

    logic                is_dec;
    logic                is_hex;
    logic [3:0]          digit;
    logic [VALUE_W-1:0]  acc_dec;
    logic [VALUE_W-1:0]  acc_hex;

    // Classify the character and extract its digit value.
    always_comb begin
        is_dec = char_code inside {[CH_0:CH_9]};
        is_hex = 1'b1;
        digit  = 4'd0;
        if (is_dec) begin
            digit = 4'(char_code - CH_0);
        end else if (char_code inside {[CH_LA:CH_LF]}) begin
            digit = 4'(char_code - CH_LA + 8'd10);
        end else if (char_code inside {[CH_UA:CH_UF]}) begin
            digit = 4'(char_code - CH_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Shift-add accumulator updates; both wrap at the word width.
    assign acc_dec = {state.acc[VALUE_W-4:0], 3'b000} + {state.acc[VALUE_W-2:0], 1'b0}
                   + VALUE_W'(digit);
    assign acc_hex = {state.acc[VALUE_W-5:0], digit};

    // The terminator result, negated when a leading minus was seen.
    assign result = state.neg ? (VALUE_W'(0) - state.acc) : state.acc;

    // Phase transitions.
    always_comb begin
        state_next = state;
        if (char_code == CH_NUL) begin
            state_next.phase = PH_START;
            state_next.acc   = '0;
            state_next.neg   = 1'b0;
        end else begin
            case (state.phase)
                PH_START: begin
                    if (char_code == CH_0) begin
                        state_next.acc   = '0;
                        state_next.phase = PH_ZERO;
                    end else if (char_code == CH_MINUS && signed_mode) begin
                        state_next.neg   = 1'b1;
                        state_next.phase = PH_DEC;
                    end else if (is_dec) begin
                        state_next.acc   = VALUE_W'(digit);
                        state_next.phase = PH_DEC;
                    end else begin
                        state_next.phase = PH_STOP;
                    end
                end
                PH_ZERO: begin
                    if (char_code == CH_X) begin
                        state_next.acc   = '0;
                        state_next.phase = PH_HEX;
                    end else if (is_dec) begin
                        state_next.acc   = acc_dec;
                        state_next.phase = PH_DEC;
                    end else begin
                        state_next.phase = PH_STOP;
                    end
                end
                PH_DEC: begin
                    if (is_dec) begin
                        state_next.acc = acc_dec;
                    end else begin
                        state_next.phase = PH_STOP;
                    end
                end
                PH_HEX: begin
                    if (is_hex) begin
                        state_next.acc = acc_hex;
                    end else begin
                        state_next.phase = PH_STOP;
                    end
                end
                default: begin
                    state_next.phase = PH_STOP;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/ascii_number_parser.sv
// Top level of the ASCII number parser: handshakes, state registers and result register.
//
// The block reads a text number one character per input beat on s_char_code.
// A zero character ends the string and produces one result beat on m_value;
// every other character produces nothing. A string starting with "0x" is read
// as hex, anything else as decimal; in signed mode a leading '-' negates the
// decimal value. Arithmetic wraps at 32 bits.
//
// Throughput is one character per cycle while s_ready is high: the accumulator
// update is a single shift-add between the state registers. A result appears on
// m_value in the cycle after its terminator is accepted and sits in one output register.
// s_ready drops only while that register is full and m_ready is low, so a
// stalled receiver holds off further characters until it takes the result.
//
// signed_mode is written through cfg_wr_en / cfg_wr_data and is sampled by
// the first character of each string. Reset (aresetn low, synchronous)
// clears signed_mode, the parse state and m_valid; the m_value register has no reset.
`default_nettype none

module ascii_number_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_char_code,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [anp_pkg::VALUE_W-1:0] m_value
);
    import anp_pkg::*;

    logic               signed_mode_reg;
    anp_state_t         state_reg;
    anp_state_t         state_next;
    logic [VALUE_W-1:0] result;
    logic [VALUE_W-1:0] value_reg;
    logic               out_valid_reg;
    logic               s_fire;
    logic               term_fire;

    // Accept a beat whenever the output register can take a result.
    assign s_ready   = !out_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign term_fire = s_fire && (s_char_code == CH_NUL);

    anp_step u_step (
        .state       (state_reg),
        .char_code   (s_char_code),
        .signed_mode (signed_mode_reg),
        .state_next  (state_next),
        .result      (result)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            signed_mode_reg <= cfg_wr_data;
        end
    end

    // Parse state advances on every accepted character.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= PH_START;
            state_reg.acc   <= '0;
            state_reg.neg   <= 1'b0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Output register: loaded by a terminator, emptied by the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (term_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (term_fire) begin
            value_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = value_reg;

    // A terminator always leaves a result waiting in the next cycle.
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        term_fire |=> out_valid_reg)
        else $error("terminator beat did not load the output register");

    // A terminator returns the string state to its start.
    a_term_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        term_fire |=> (state_reg.phase == PH_START && state_reg.acc == '0 && !state_reg.neg))
        else $error("string state not cleared after terminator");

    // The minus flag only lives in the decimal or stopped phases.
    a_neg_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.neg |-> (state_reg.phase == PH_DEC || state_reg.phase == PH_STOP))
        else $error("negative flag set outside decimal parse");

    // A non-terminator never disturbs a pending result.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && !term_fire) |=> (out_valid_reg && $stable(value_reg)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire
